// ----- design/sfr_pkg.sv -----
package sfr_pkg;

    // Field widths of the item channels
    localparam int OPCODE_W = 3;
    localparam int NID_W    = 12;
    localparam int CROSS_W  = 11;
    localparam int NODE_W   = 3;
    localparam int TARGET_W = 17;
    localparam int SLOT_W   = 12;
    localparam int MID_W    = 16;
    localparam int COUNT_W  = 4;

    // Magnitude bits of a non-negative cross index
    localparam int CI_W = CROSS_W - 1;

    // Per-node fill count and its ceiling
    localparam int FILL_W = 13;
    localparam logic [FILL_W-1:0] FILL_MAX = '1;

    // Hard limit on nodes scanned per fired neuron
    localparam int SCAN_MAX = 8;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD_NEURON = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_CROSS  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SET_BASE    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_FILL  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FIRE        = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic              nt_we;     // write neuron table
        logic              mt_we;     // write node map table
        logic              base_we;   // write node base
        logic              fill_clr;  // zero all fill counts
        logic              nt_re;     // read neuron table at fired id
        logic              ci_ld;     // capture cross index
        logic              mt_re;     // read node map entry
        logic [NODE_W-1:0] mt_node;   // node of that read
        logic              eval;      // evaluate map entry in read register
        logic [NODE_W-1:0] eval_node; // node of that entry
        logic              flush;     // push pending result out as last
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic nid_ok;    // fired id within neuron table
        logic ci_ok;     // stored cross index within range
        logic mid_ok;    // map entry holds a valid id
        logic pend_vld;  // pending result held
        logic out_busy;  // output register full and not taken
    } t_sts;

endpackage

// ----- design/sfr_in_if.sv -----
interface sfr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [sfr_pkg::OPCODE_W-1:0]         opcode;
    logic [sfr_pkg::NID_W-1:0]            neuron_id;
    logic signed [sfr_pkg::CROSS_W-1:0]   cross_index;
    logic [sfr_pkg::NODE_W-1:0]           dest_node;
    logic signed [sfr_pkg::TARGET_W-1:0]  target_id;
    logic [sfr_pkg::SLOT_W-1:0]           base_slot;

    modport source (output valid, output opcode, output neuron_id, output cross_index,
                    output dest_node, output target_id, output base_slot, input ready);
    modport sink   (input valid, input opcode, input neuron_id, input cross_index,
                    input dest_node, input target_id, input base_slot, output ready);
endinterface

// ----- design/sfr_out_if.sv -----
interface sfr_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::NODE_W-1:0]    out_node;
    logic [sfr_pkg::SLOT_W-1:0]    slot_address;
    logic [sfr_pkg::MID_W-1:0]     mapped_id;
    logic                          overflow;
    logic                          last;

    modport source (output valid, output out_node, output slot_address, output mapped_id,
                    output overflow, output last, input ready);
    modport sink   (input valid, input out_node, input slot_address, input mapped_id,
                    input overflow, input last, output ready);
endinterface

// ----- design/sfr_cfg_if.sv -----
interface sfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::COUNT_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/sfr_ram.sv -----
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- design/sfr_ctrl.sv -----
module sfr_ctrl #(
    parameter int NODES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sfr_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sfr_pkg::OPCODE_W-1:0] i_opcode,
    input  sfr_pkg::t_sts                i_sts,
    output sfr_pkg::t_cmd                o_cmd
);

    localparam int NSLOT = (NODES < sfr_pkg::SCAN_MAX) ? NODES : sfr_pkg::SCAN_MAX;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_NWAIT = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [sfr_pkg::COUNT_W-1:0]  r_node_count;
    logic [sfr_pkg::COUNT_W-1:0]  r_scan, n_scan;
    logic [sfr_pkg::COUNT_W-1:0]  r_issue, n_issue;
    logic                         r_ev_vld, n_ev_vld;
    logic [sfr_pkg::NODE_W-1:0]   r_ev_node, n_ev_node;
    logic                         in_fire;
    logic                         stall;
    logic                         issue;
    logic [sfr_pkg::COUNT_W-1:0]  scan_lim;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;

    // Clip the scan length to the node slots
    assign scan_lim = (r_node_count > sfr_pkg::COUNT_W'(NSLOT)) ?
                      sfr_pkg::COUNT_W'(NSLOT) : r_node_count;

    // Hold the scan while a new result finds both result registers full
    assign stall = r_ev_vld && i_sts.mid_ok && i_sts.pend_vld && i_sts.out_busy;
    assign issue = (r_issue < r_scan);

    // Node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= sfr_pkg::COUNT_W'(8);
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_scan    = r_scan;
        n_issue   = r_issue;
        n_ev_vld  = r_ev_vld;
        n_ev_node = r_ev_node;
        o_cmd     = '0;
        o_cmd.mt_node   = r_issue[sfr_pkg::NODE_W-1:0];
        o_cmd.eval_node = r_ev_node;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_opcode)
                        sfr_pkg::OP_LOAD_NEURON: o_cmd.nt_we    = 1'b1;
                        sfr_pkg::OP_LOAD_CROSS:  o_cmd.mt_we    = 1'b1;
                        sfr_pkg::OP_SET_BASE:    o_cmd.base_we  = 1'b1;
                        sfr_pkg::OP_CLEAR_FILL:  o_cmd.fill_clr = 1'b1;
                        sfr_pkg::OP_FIRE: begin
                            o_cmd.nt_re = 1'b1;
                            if (i_sts.nid_ok) begin
                                n_state = ST_NWAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_NWAIT: begin
                o_cmd.ci_ld = 1'b1;
                n_scan      = scan_lim;
                n_issue     = '0;
                n_ev_vld    = 1'b0;
                if (i_sts.ci_ok && (scan_lim != '0)) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    o_cmd.mt_re = issue;
                    o_cmd.eval  = r_ev_vld;
                    n_ev_vld    = issue;
                    n_ev_node   = r_issue[sfr_pkg::NODE_W-1:0];
                    if (issue) begin
                        n_issue = r_issue + 1'b1;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (!i_sts.pend_vld || !i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_scan    <= '0;
            r_issue   <= '0;
            r_ev_vld  <= 1'b0;
            r_ev_node <= '0;
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_issue   <= n_issue;
            r_ev_vld  <= n_ev_vld;
            r_ev_node <= n_ev_node;
        end
    end

`ifndef NO_ASSERTIONS
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issue <= r_scan))
        else $error("issue counter ran past scan length");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && stall) |=> ($stable(r_issue) && $stable(r_ev_node)))
        else $error("scan advanced during a stall");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FLUSH) && !i_sts.pend_vld) |=> (r_state == ST_IDLE))
        else $error("flush did not return to idle");
`endif

endmodule

// ----- design/sfr_dpath.sv -----
module sfr_dpath #(
    parameter int NEURONS       = 4096,
    parameter int CROSS_ENTRIES = 1024,
    parameter int NODES         = 8,
    parameter int BUF_DEPTH     = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfr_pkg::t_cmd                       i_cmd,
    output sfr_pkg::t_sts                       o_sts,
    input  logic [sfr_pkg::NID_W-1:0]           i_neuron_id,
    input  logic signed [sfr_pkg::CROSS_W-1:0]  i_cross_index,
    input  logic [sfr_pkg::NODE_W-1:0]          i_dest_node,
    input  logic signed [sfr_pkg::TARGET_W-1:0] i_target_id,
    input  logic [sfr_pkg::SLOT_W-1:0]          i_base_slot,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sfr_pkg::NODE_W-1:0]          o_out_node,
    output logic [sfr_pkg::SLOT_W-1:0]          o_slot_address,
    output logic [sfr_pkg::MID_W-1:0]           o_mapped_id,
    output logic                                o_overflow,
    output logic                                o_last
);

    localparam int NSLOT    = (NODES < sfr_pkg::SCAN_MAX) ? NODES : sfr_pkg::SCAN_MAX;
    localparam int NS_W     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int NT_AW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int MT_DEPTH = CROSS_ENTRIES * NODES;
    localparam int MT_AW    = (MT_DEPTH > 1) ? $clog2(MT_DEPTH) : 1;
    localparam int SUM_W    = sfr_pkg::FILL_W + 1;

    logic [sfr_pkg::CROSS_W-1:0]  nt_rdata;
    logic [sfr_pkg::TARGET_W-1:0] mt_rdata;
    logic [NT_AW-1:0]             nt_addr;
    logic [MT_AW-1:0]             mt_waddr, mt_raddr;
    logic                         nid_ok, xload_ok, dest_ok;
    logic [sfr_pkg::CI_W-1:0]     r_ci;
    logic [sfr_pkg::SLOT_W-1:0]   r_base [NSLOT];
    logic [sfr_pkg::FILL_W-1:0]   r_fill [NSLOT];
    logic [NS_W-1:0]              ev_idx;
    logic [SUM_W-1:0]             slot_sum;
    logic                         ovf;
    logic                         mid_ok;
    logic                         out_busy;
    logic                         take_new;
    logic                         push_pend;

    // Pending result, waiting to learn whether it is the last one
    logic                         r_p_vld;
    logic [sfr_pkg::NODE_W-1:0]   r_p_node;
    logic [sfr_pkg::SLOT_W-1:0]   r_p_slot;
    logic [sfr_pkg::MID_W-1:0]    r_p_mid;
    logic                         r_p_ovf;

    // Output register
    logic                         r_o_vld;
    logic [sfr_pkg::NODE_W-1:0]   r_o_node;
    logic [sfr_pkg::SLOT_W-1:0]   r_o_slot;
    logic [sfr_pkg::MID_W-1:0]    r_o_mid;
    logic                         r_o_ovf;
    logic                         r_o_last;

    // Range checks on the incoming item
    assign nid_ok   = (32'(i_neuron_id) < NEURONS);
    assign xload_ok = !i_cross_index[sfr_pkg::CROSS_W-1] &&
                      (32'(i_cross_index[sfr_pkg::CI_W-1:0]) < CROSS_ENTRIES) &&
                      (32'(i_dest_node) < NODES);
    assign dest_ok  = (32'(i_dest_node) < NODES);

    assign nt_addr  = NT_AW'(i_neuron_id);
    assign mt_waddr = MT_AW'(32'(i_cross_index[sfr_pkg::CI_W-1:0]) * NODES +
                             32'(i_dest_node));
    assign mt_raddr = MT_AW'(32'(r_ci) * NODES + 32'(i_cmd.mt_node));

    sfr_ram #(
        .WIDTH (sfr_pkg::CROSS_W),
        .DEPTH (NEURONS)
    ) u_neuron_tbl (
        .i_clk   (i_clk),
        .i_we    (i_cmd.nt_we && nid_ok),
        .i_waddr (nt_addr),
        .i_wdata (i_cross_index),
        .i_re    (i_cmd.nt_re),
        .i_raddr (nt_addr),
        .o_rdata (nt_rdata)
    );

    sfr_ram #(
        .WIDTH (sfr_pkg::TARGET_W),
        .DEPTH (MT_DEPTH)
    ) u_map_tbl (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mt_we && xload_ok),
        .i_waddr (mt_waddr),
        .i_wdata (i_target_id),
        .i_re    (i_cmd.mt_re),
        .i_raddr (mt_raddr),
        .o_rdata (mt_rdata)
    );

    // Evaluate the map entry of the current node
    assign ev_idx   = i_cmd.eval_node[NS_W-1:0];
    assign mid_ok   = !mt_rdata[sfr_pkg::TARGET_W-1];
    assign slot_sum = SUM_W'(r_base[ev_idx]) + SUM_W'(r_fill[ev_idx]);
    assign ovf      = (32'(slot_sum) >= BUF_DEPTH);
    assign out_busy = r_o_vld && !i_out_ready;

    assign take_new  = i_cmd.eval && mid_ok;
    assign push_pend = r_p_vld && !out_busy && (take_new || i_cmd.flush);

    assign o_sts.nid_ok   = nid_ok;
    assign o_sts.ci_ok    = !nt_rdata[sfr_pkg::CROSS_W-1] &&
                            (32'(nt_rdata[sfr_pkg::CI_W-1:0]) < CROSS_ENTRIES);
    assign o_sts.mid_ok   = mid_ok;
    assign o_sts.pend_vld = r_p_vld;
    assign o_sts.out_busy = out_busy;

    // Capture cross index of the fired neuron
    always_ff @(posedge i_clk) begin
        if (i_cmd.ci_ld) begin
            r_ci <= nt_rdata[sfr_pkg::CI_W-1:0];
        end
    end

    // Node base and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSLOT; k++) begin
                r_base[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            if (i_cmd.base_we && dest_ok) begin
                r_base[i_dest_node[NS_W-1:0]] <= i_base_slot;
            end
            if (i_cmd.fill_clr) begin
                for (int k = 0; k < NSLOT; k++) begin
                    r_fill[k] <= '0;
                end
            end else if (take_new && !ovf && (r_fill[ev_idx] != sfr_pkg::FILL_MAX)) begin
                r_fill[ev_idx] <= r_fill[ev_idx] + 1'b1;
            end
        end
    end

    // Pending and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (take_new) begin
                r_p_vld <= 1'b1;
            end else if (push_pend) begin
                r_p_vld <= 1'b0;
            end
            if (push_pend) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Result payloads
    always_ff @(posedge i_clk) begin
        if (take_new) begin
            r_p_node <= i_cmd.eval_node;
            r_p_slot <= slot_sum[sfr_pkg::SLOT_W-1:0];
            r_p_mid  <= mt_rdata[sfr_pkg::MID_W-1:0];
            r_p_ovf  <= ovf;
        end
        if (push_pend) begin
            r_o_node <= r_p_node;
            r_o_slot <= r_p_slot;
            r_o_mid  <= r_p_mid;
            r_o_ovf  <= r_p_ovf;
            r_o_last <= i_cmd.flush;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_out_node     = r_o_node;
    assign o_slot_address = r_o_slot;
    assign o_mapped_id    = r_o_mid;
    assign o_overflow     = r_o_ovf;
    assign o_last         = r_o_last;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_new && r_p_vld) |-> !out_busy)
        else $error("pending result overwritten while output register full");

    a_fill_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_clr |=> (r_fill[0] == '0))
        else $error("fill count not cleared");
`endif

endmodule

// ----- design/spike_fanout_router_core.sv -----
// Channel   Dir  Handshake       Item
// i_cfg     in   valid / ready   node_count write (always ready)
// i_in      in   valid / ready   opcode, neuron_id, cross_index, dest_node, target_id, base_slot
// o_out     out  valid / ready   out_node, slot_address, mapped_id, overflow, last
//
// Load, base and clear items are applied as they are accepted; the block stays ready for the next item.
// A fire reads the neuron table, captures the cross index, scans N nodes and flushes, N being
// the nodes scanned (node_count clipped to min(NODES, 8)); the node map table's single read port
// allows one node per cycle when no stall holds the scan; no new item is taken until the fire ends.
// Results leave through an output register; a stalled output stops the node scan
// only when a second valid mapping arrives behind a held result.
// Synchronous active-low reset clears control, node bases, fill counts and node_count
// (to 8); the two tables hold no reset and read undefined until written.
module spike_fanout_router_core #(
    parameter int NEURONS       = 4096,
    parameter int CROSS_ENTRIES = 1024,
    parameter int NODES         = 8,
    parameter int BUF_DEPTH     = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfr_cfg_if.sink   i_cfg,
    sfr_in_if.sink    i_in,
    sfr_out_if.source o_out
);

    sfr_pkg::t_cmd cmd;
    sfr_pkg::t_sts sts;

    sfr_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_data  (i_cfg.data),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_opcode    (i_in.opcode),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sfr_dpath #(
        .NEURONS       (NEURONS),
        .CROSS_ENTRIES (CROSS_ENTRIES),
        .NODES         (NODES),
        .BUF_DEPTH     (BUF_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_neuron_id    (i_in.neuron_id),
        .i_cross_index  (i_in.cross_index),
        .i_dest_node    (i_in.dest_node),
        .i_target_id    (i_in.target_id),
        .i_base_slot    (i_in.base_slot),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_node     (o_out.out_node),
        .o_slot_address (o_out.slot_address),
        .o_mapped_id    (o_out.mapped_id),
        .o_overflow     (o_out.overflow),
        .o_last         (o_out.last)
    );

endmodule
